// ===== rtl/core/e2e_pkg.sv =====
// Shared types and constants for the E2E CRC-8 protect/check core.
// Beat structs, status codes and CRC constants. No dependencies.
package e2e_pkg;

    localparam logic [7:0] CRC_POLY   = 8'h1D;
    localparam logic [7:0] CRC_INIT   = 8'hFF;
    localparam logic [3:0] ALIVE_MASK = 4'hF;

    localparam logic       OP_PROTECT = 1'b0;
    localparam logic       OP_CHECK   = 1'b1;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_SHORT    = 2'd1;
    localparam logic [1:0] STAT_MISMATCH = 2'd2;

    typedef struct packed {
        logic       op;
        logic [7:0] data_id;
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] crc_value;
        logic [3:0] alive_nibble;
        logic [7:0] second_byte_out;
    } t_out_beat;

endpackage

// ===== rtl/core/e2e_crc8_unit.sv =====
// One-byte CRC-8 update, SAE J1850 polynomial, MSB first, no reflection.
// Depends on e2e_pkg for the polynomial.
module e2e_crc8_unit (
    input  logic [7:0] i_crc,
    input  logic [7:0] i_byte,
    output logic [7:0] o_crc
);

    always_comb begin
        logic [7:0] c;
        c = i_crc ^ i_byte;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ e2e_pkg::CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        o_crc = c;
    end

endmodule

// ===== rtl/core/e2e_frame_unit.sv =====
// Frame state (position, mode, CRC accumulator, stored bytes, alive counter)
// and result formation. Depends on e2e_pkg and e2e_crc8_unit.
module e2e_frame_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  e2e_pkg::t_in_beat  i_beat,
    output e2e_pkg::t_out_beat o_res
);

    localparam logic [1:0] POS_CRC  = 2'd0;
    localparam logic [1:0] POS_SEC  = 2'd1;
    localparam logic [1:0] POS_BODY = 2'd2;

    logic [1:0] r_pos,   n_pos;
    logic       r_mode,  n_mode;
    logic [7:0] r_crc,   n_crc;
    logic [7:0] r_rcrc,  n_rcrc;
    logic [7:0] r_sb,    n_sb;
    logic [3:0] r_alive, n_alive;

    logic [7:0] byte_eff;
    logic [7:0] sb_cur;
    logic [7:0] crc_new;

    // alive nibble goes into byte 1 on protect
    assign byte_eff = (r_pos == POS_SEC && r_mode == e2e_pkg::OP_PROTECT)
                    ? {i_beat.frame_byte[7:4], r_alive}
                    : i_beat.frame_byte;
    assign sb_cur   = (r_pos == POS_SEC) ? byte_eff : r_sb;

    e2e_crc8_unit u_crc (
        .i_crc  (r_crc),
        .i_byte (byte_eff),
        .o_crc  (crc_new)
    );

    always_comb begin
        n_pos   = r_pos;
        n_mode  = r_mode;
        n_crc   = r_crc;
        n_rcrc  = r_rcrc;
        n_sb    = r_sb;
        n_alive = r_alive;
        o_res   = '0;
        case (r_pos)
            POS_CRC: begin
                n_mode = i_beat.op;
                n_crc  = e2e_pkg::CRC_INIT ^ i_beat.data_id;
                n_rcrc = i_beat.frame_byte;
                n_pos  = i_beat.last_byte ? POS_CRC : POS_SEC;
                o_res.status = e2e_pkg::STAT_SHORT;
            end
            POS_SEC, POS_BODY: begin
                n_crc = crc_new;
                n_sb  = sb_cur;
                n_pos = i_beat.last_byte ? POS_CRC : POS_BODY;
                o_res.crc_value       = crc_new;
                o_res.second_byte_out = sb_cur;
                if (r_mode == e2e_pkg::OP_PROTECT) begin
                    o_res.status       = e2e_pkg::STAT_OK;
                    o_res.alive_nibble = r_alive;
                    if (i_beat.last_byte) begin
                        n_alive = (r_alive + 4'd1) & e2e_pkg::ALIVE_MASK;
                    end
                end else begin
                    o_res.status       = (crc_new == r_rcrc) ? e2e_pkg::STAT_OK
                                                             : e2e_pkg::STAT_MISMATCH;
                    o_res.alive_nibble = sb_cur[3:0];
                end
            end
            default: begin
                n_pos = POS_CRC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= POS_CRC;
            r_mode  <= e2e_pkg::OP_PROTECT;
            r_crc   <= '0;
            r_rcrc  <= '0;
            r_sb    <= '0;
            r_alive <= '0;
        end else if (i_step) begin
            r_pos   <= n_pos;
            r_mode  <= n_mode;
            r_crc   <= n_crc;
            r_rcrc  <= n_rcrc;
            r_sb    <= n_sb;
            r_alive <= n_alive;
        end
    end

endmodule

// ===== rtl/core/e2e_crc8_protect_check_core.sv =====
// Top level of the E2E CRC-8 protect/check core: input stage, frame unit,
// result register. Depends on e2e_pkg and e2e_frame_unit.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_beat) carries one frame
//   byte per beat, byte 0 (the CRC slot) first; last_byte marks the end.
//   op and data_id are taken from byte 0 only. Output channel
//   (o_out_valid / i_out_ready / o_out_beat) carries one result beat per
//   frame: status, computed CRC, alive nibble and final byte 1.
//   Protect (op 0) puts the transmit alive counter into the low nibble of
//   byte 1 and advances it after each frame of two bytes or more; check (op 1)
//   compares the CRC against byte 0. A frame of one byte reports "short".
// Timing:
//   One beat per cycle, unless a final byte waits for the result register. A
//   beat sits in the input register while the 8-step CRC update runs on it;
//   a last byte leaving it is loaded into the result register, raising o_out_valid.
// Reset: clears both valid flags, the frame position and the alive counter.
// Stall: while a result waits, non-final bytes keep flowing; a final byte
//   waits in the input register until the result register frees up, and
//   o_in_ready then follows i_out_ready.
module e2e_crc8_protect_check_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  e2e_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output e2e_pkg::t_out_beat o_out_beat
);

    // input stage
    logic               r_s1_vld;
    e2e_pkg::t_in_beat  r_s1;
    // result register
    logic               r_out_vld;
    e2e_pkg::t_out_beat r_out;

    logic               out_free;
    logic               s1_drain;
    logic               load_res;
    e2e_pkg::t_out_beat res;

    assign out_free   = !r_out_vld || i_out_ready;
    // non-final bytes never need the result register
    assign s1_drain   = r_s1_vld && (!r_s1.last_byte || out_free);
    assign load_res   = s1_drain && r_s1.last_byte;
    assign o_in_ready = !r_s1_vld || s1_drain;

    e2e_frame_unit u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (s1_drain),
        .i_beat  (r_s1),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1 <= i_in_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= load_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_res) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_beat  = r_out;

    // a mid-frame byte is never held back
    a_body_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !r_s1.last_byte) |-> s1_drain)
        else $error("mid-frame byte stalled");

    // a final byte leaving the input stage always shows up as a result
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_res |=> o_out_valid)
        else $error("final byte produced no result");

    // short frames report all-zero payload fields
    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.status == e2e_pkg::STAT_SHORT) |->
        (o_out_beat.crc_value == 8'd0 && o_out_beat.alive_nibble == 4'd0 &&
         o_out_beat.second_byte_out == 8'd0))
        else $error("short frame result carries data");

endmodule
